[rtl/client_session_table_with_timeout_core_assert.svh]
// assertion macros for the rtl files, included by cst_datapath
`ifndef CLIENT_SESSION_TABLE_WITH_TIMEOUT_CORE_ASSERT_SVH
`define CLIENT_SESSION_TABLE_WITH_TIMEOUT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CST_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");
`define CST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define CST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define CST_ASSERT_ALW(lbl, expr)
`define CST_ASSERT_IMP(lbl, ante, cons)
`define CST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/cst_pkg.sv]
package cst_pkg;

  localparam int NUM_ENTRIES  = 8;
  localparam int IDX_W        = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int ENTRY_IDX_W  = 3;
  localparam int IDX_EXT_W    = (IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W;
  localparam int ADDR_W       = 32;
  localparam int TIME_W       = 32;
  localparam int TIMEOUT_W    = 31;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(3 * 60 * 1000);
  localparam logic [APB_AW-1:0]    REG_IDLE_TIMEOUT = APB_AW'(0);

  typedef enum logic [1:0] {
    FUNC_CHECK  = 2'd0,
    FUNC_LOGIN  = 2'd1,
    FUNC_LOGOUT = 2'd2,
    FUNC_SWEEP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/cst_ctrl.sv]
module cst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cst_pkg::sts_t sts,
  output cst_pkg::cmd_t cmd
);

  cst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      cst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = cst_pkg::ST_SCAN;
        end
      end
      cst_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = cst_pkg::ST_FINISH;
        end
      end
      cst_pkg::ST_FINISH: begin
        // hold the finished item until the output register can take it
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = cst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/cst_datapath.sv]
`include "client_session_table_with_timeout_core_assert.svh"

module cst_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cst_pkg::cmd_t                     cmd,
  output cst_pkg::sts_t                     sts,
  input  logic [1:0]                        in_func,
  input  logic [cst_pkg::ADDR_W-1:0]        in_client_addr,
  input  logic [cst_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                              in_credentials_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_granted,
  output logic                              out_no_free_entry,
  output logic                              out_leds_off,
  output logic [cst_pkg::ENTRY_IDX_W-1:0]   out_entry_index,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cst_pkg::APB_AW-1:0]        paddr,
  input  logic [cst_pkg::APB_DW-1:0]        pwdata,
  output logic [cst_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int N = cst_pkg::NUM_ENTRIES;

  // captured item
  cst_pkg::func_t                 func_r;
  logic [cst_pkg::ADDR_W-1:0]     addr_r;
  logic [cst_pkg::TIME_W-1:0]     now_r;
  logic                           cred_r;

  logic [cst_pkg::TIMEOUT_W-1:0]  timeout_r;

  // session table
  logic                           used_r [N];
  logic                           auth_r [N];
  logic [cst_pkg::ADDR_W-1:0]     eaddr_r [N];
  logic [cst_pkg::TIME_W-1:0]     last_r [N];

  // scan state
  logic [cst_pkg::IDX_W-1:0]      cnt_r;
  logic                           match_found_r;
  logic [cst_pkg::IDX_W-1:0]      match_idx_r;
  logic                           match_auth_r;
  logic                           free_found_r;
  logic [cst_pkg::IDX_W-1:0]      free_idx_r;
  logic                           leds_acc_r;

  // result register
  logic                           out_valid_r;
  logic                           granted_r;
  logic                           nofree_r;
  logic                           leds_r;
  logic [cst_pkg::ENTRY_IDX_W-1:0] idx_r;

  logic [cst_pkg::TIME_W-1:0]     elapsed;
  logic                           stale_k;
  logic                           addr_hit_k;
  logic                           cfg_wr;
  logic                           is_sweep;
  logic                           do_lookup;
  logic                           hit;
  logic                           claim;
  logic                           auth_eff;
  logic [cst_pkg::IDX_W-1:0]      sel;
  logic [cst_pkg::IDX_EXT_W-1:0]  sel_ext;
  logic                           touch;
  logic                           granted_nxt;
  logic                           nofree_nxt;
  logic                           leds_nxt;
  logic [cst_pkg::ENTRY_IDX_W-1:0] idx_nxt;

  // per-entry checks at the scan pointer
  assign elapsed    = now_r - last_r[cnt_r];
  assign stale_k    = elapsed > {1'b0, timeout_r};
  assign addr_hit_k = used_r[cnt_r] && (eaddr_r[cnt_r] == addr_r);

  assign sts.scan_last = (cnt_r == cst_pkg::IDX_W'(N - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // finish-step decode
  assign is_sweep  = (func_r == cst_pkg::FUNC_SWEEP);
  assign do_lookup = !is_sweep && ((func_r != cst_pkg::FUNC_LOGIN) || cred_r);
  assign hit       = match_found_r || free_found_r;
  assign claim     = !match_found_r && free_found_r;
  assign auth_eff  = match_found_r && match_auth_r;
  assign sel       = match_found_r ? match_idx_r : free_idx_r;
  assign sel_ext   = cst_pkg::IDX_EXT_W'(sel);
  assign touch     = claim || (func_r == cst_pkg::FUNC_LOGIN) ||
                     ((func_r == cst_pkg::FUNC_CHECK) && auth_eff);

  always_comb begin
    granted_nxt = do_lookup && hit &&
                  (((func_r == cst_pkg::FUNC_CHECK) && auth_eff) ||
                   (func_r == cst_pkg::FUNC_LOGIN));
    nofree_nxt  = do_lookup && !hit;
    leds_nxt    = is_sweep ? leds_acc_r : (func_r == cst_pkg::FUNC_LOGOUT);
    idx_nxt     = (do_lookup && hit) ? sel_ext[cst_pkg::ENTRY_IDX_W-1:0] : '0;
  end

  assign cfg_wr = psel && penable && pwrite && (paddr == cst_pkg::REG_IDLE_TIMEOUT);
  assign pready = 1'b1;
  assign prdata = (paddr == cst_pkg::REG_IDLE_TIMEOUT) ?
                  cst_pkg::APB_DW'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cst_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_r <= pwdata[cst_pkg::TIMEOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= cst_pkg::func_t'(in_func);
      addr_r <= in_client_addr;
      now_r  <= in_now_ms;
      cred_r <= in_credentials_ok;
    end
  end

  // scan pointer and first-match / first-claimable search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      leds_acc_r    <= 1'b0;
    end else if (cmd.load) begin
      cnt_r         <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      leds_acc_r    <= 1'b0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + 1'b1;
      if (is_sweep) begin
        if (auth_r[cnt_r] && stale_k) begin
          leds_acc_r <= 1'b1;
        end
      end else begin
        if (!match_found_r && addr_hit_k) begin
          match_found_r <= 1'b1;
        end
        if (!free_found_r && (!auth_r[cnt_r] || stale_k)) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && !is_sweep) begin
      if (!match_found_r && addr_hit_k) begin
        match_idx_r  <= cnt_r;
        // a stale match loses its authentication
        match_auth_r <= auth_r[cnt_r] && !stale_k;
      end
      if (!free_found_r && (!auth_r[cnt_r] || stale_k)) begin
        free_idx_r <= cnt_r;
      end
    end
  end

  // table flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        used_r[i] <= 1'b0;
        auth_r[i] <= 1'b0;
      end
    end else if (cmd.scan && is_sweep) begin
      if (auth_r[cnt_r] && stale_k) begin
        auth_r[cnt_r] <= 1'b0;
      end
    end else if (cmd.finish && do_lookup && hit) begin
      if (claim) begin
        used_r[sel] <= 1'b1;
      end
      case (func_r)
        cst_pkg::FUNC_CHECK:  auth_r[sel] <= auth_eff;
        cst_pkg::FUNC_LOGIN:  auth_r[sel] <= 1'b1;
        cst_pkg::FUNC_LOGOUT: auth_r[sel] <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    if (cmd.finish && do_lookup && hit) begin
      if (claim) begin
        eaddr_r[sel] <= addr_r;
      end
      if (touch) begin
        last_r[sel] <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      granted_r <= granted_nxt;
      nofree_r  <= nofree_nxt;
      leds_r    <= leds_nxt;
      idx_r     <= idx_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = granted_r;
  assign out_no_free_entry = nofree_r;
  assign out_leds_off      = leds_r;
  assign out_entry_index   = idx_r;

  `CST_ASSERT_ALW(a_cmd_onehot, $onehot0({cmd.load, cmd.scan, cmd.finish}))
  `CST_ASSERT_IMP(a_finish_needs_room, cmd.finish, !out_valid_r || out_ready)
  `CST_ASSERT_NXT(a_finish_shows_result, cmd.finish, out_valid_r)

endmodule

[rtl/client_session_table_with_timeout_core.sv]
// session table with idle timeout, keyed by client ipv4 address
// input channel (in_*): one operation per transfer: check, login, logout or
//   sweep, with the client address, the current time in ms and the
//   credential-valid bit
// result channel (out_*): exactly one result transfer per input transfer
//   with granted, no_free_entry, leds_off and the entry index used
// config (apb): idle timeout in ms at byte address 0, write only while idle
// processing: the sequential scan visits each table entry in turn through
//   the single entry-compare unit, then a finish step updates the entry
//   and loads the output register
// intake: a new item is taken only after the previous one has been loaded
//   into the output register, while its result may still wait for the
//   receiver; no new item is taken during a scan
// stall: if the receiver holds out_ready low, the finished item waits in
//   the controller until the output register frees, and no new item is
//   accepted meanwhile
// reset: all entries unused and unauthenticated, timeout back to 180000 ms
module client_session_table_with_timeout_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic [cst_pkg::ADDR_W-1:0]        in_client_addr,
  input  logic [cst_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                              in_credentials_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_granted,
  output logic                              out_no_free_entry,
  output logic                              out_leds_off,
  output logic [cst_pkg::ENTRY_IDX_W-1:0]   out_entry_index,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cst_pkg::APB_AW-1:0]        paddr,
  input  logic [cst_pkg::APB_DW-1:0]        pwdata,
  output logic [cst_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cst_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_client_addr    (in_client_addr),
    .in_now_ms         (in_now_ms),
    .in_credentials_ok (in_credentials_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_no_free_entry (out_no_free_entry),
    .out_leds_off      (out_leds_off),
    .out_entry_index   (out_entry_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

endmodule
